### src/cecpwr_pkg.sv
// ----------------------------------------------------------------------------
// CEC pulse width receiver package
// Shared types and constants for the CEC receive bit decoder.
// ----------------------------------------------------------------------------
package cecpwr_pkg;

	// width of the low time and of each configuration register
	localparam int unsigned TICKW = 16;

	// configuration register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_START_LOW = 2'd0;
	localparam logic [1:0] REG_ONE_LOW   = 2'd1;
	localparam logic [1:0] REG_ZERO_LOW  = 2'd2;
	localparam logic [1:0] REG_TOL       = 2'd3;

	// reset values of the configuration registers
	localparam logic [TICKW-1:0] RST_START_LOW = 16'd7400;
	localparam logic [TICKW-1:0] RST_ONE_LOW   = 16'd1200;
	localparam logic [TICKW-1:0] RST_ZERO_LOW  = 16'd3000;
	localparam logic [TICKW-1:0] RST_TOL       = 16'd400;

	// data bit positions with a special meaning
	localparam logic [3:0] BIT_LAST_DATA = 4'd7;
	localparam logic [3:0] BIT_EOM       = 4'd8;
	localparam logic [3:0] BIT_ACK       = 4'd9;

	// event codes reported with each result word
	typedef enum logic [2:0] {
		EV_BIT   = 3'd0,
		EV_START = 3'd1,
		EV_BYTE  = 3'd2,
		EV_EOM   = 3'd3,
		EV_ERROR = 3'd4,
		EV_ACK   = 3'd5,
		EV_IDLE  = 3'd6,
		EV_STRAY = 3'd7
	} event_t;

	// configuration register set
	typedef struct packed {
		logic [TICKW-1:0] start_low;
		logic [TICKW-1:0] one_low;
		logic [TICKW-1:0] zero_low;
		logic [TICKW-1:0] tol;
	} cfg_t;

	// window hits for one low time
	typedef struct packed {
		logic start_hit;
		logic one_hit;
		logic zero_hit;
	} class_t;

	// one result word
	typedef struct packed {
		event_t     event_code;
		logic [7:0] data_byte;
		logic [3:0] byte_index;
		logic       message_done;
		logic       ack_flag;
	} result_t;

endpackage

### src/cecpwr_regs.sv
// ----------------------------------------------------------------------------
// CEC pulse width receiver configuration registers
// APB register file holding the nominal low times and window tolerance.
// ----------------------------------------------------------------------------
module cecpwr_regs import cecpwr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low <= RST_START_LOW;
			cfg_q.one_low   <= RST_ONE_LOW;
			cfg_q.zero_low  <= RST_ZERO_LOW;
			cfg_q.tol       <= RST_TOL;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_START_LOW: cfg_q.start_low <= pwdata[TICKW-1:0];
				REG_ONE_LOW:   cfg_q.one_low   <= pwdata[TICKW-1:0];
				REG_ZERO_LOW:  cfg_q.zero_low  <= pwdata[TICKW-1:0];
				REG_TOL:       cfg_q.tol       <= pwdata[TICKW-1:0];
				default:       ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			REG_START_LOW: prdata = {16'd0, cfg_q.start_low};
			REG_ONE_LOW:   prdata = {16'd0, cfg_q.one_low};
			REG_ZERO_LOW:  prdata = {16'd0, cfg_q.zero_low};
			REG_TOL:       prdata = {16'd0, cfg_q.tol};
			default:       prdata = 32'd0;
		endcase
	end

endmodule

### src/cecpwr_classify.sv
// ----------------------------------------------------------------------------
// CEC pulse width receiver window classifier
// Checks a low time against the start, one and zero windows.
// ----------------------------------------------------------------------------
module cecpwr_classify import cecpwr_pkg::*; (
	input  logic [TICKW-1:0] low_time,
	input  cfg_t             cfg,
	output class_t           cls
);

	// nominal +/- tolerance, exclusive bounds, no wrap
	function automatic logic in_window(input logic [TICKW-1:0] d,
		input logic [TICKW-1:0] nominal, input logic [TICKW-1:0] tol);
		logic [TICKW:0] d_plus;
		logic [TICKW:0] nom_plus;
		d_plus   = {1'b0, d} + {1'b0, tol};
		nom_plus = {1'b0, nominal} + {1'b0, tol};
		return (d_plus > {1'b0, nominal}) && ({1'b0, d} < nom_plus);
	endfunction

	assign cls.start_hit = in_window(low_time, cfg.start_low, cfg.tol);
	assign cls.one_hit   = in_window(low_time, cfg.one_low, cfg.tol);
	assign cls.zero_hit  = in_window(low_time, cfg.zero_low, cfg.tol);

endmodule

### src/cecpwr_decode.sv
// ----------------------------------------------------------------------------
// CEC pulse width receiver bit decoder
// Frame state, bit shifter and byte counter; forms one result per edge.
// ----------------------------------------------------------------------------
module cecpwr_decode import cecpwr_pkg::*; #(
	parameter int unsigned MAX_MESSAGE_BYTES = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  logic    edge_level,
	input  class_t  cls,
	output result_t result
);

	localparam int unsigned CW = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_MESSAGE_BYTES);
	localparam logic [CW-1:0] CNT_LAST = CW'(MAX_MESSAGE_BYTES - 1);

	logic          start_seen_q, start_seen_d;
	logic [3:0]    bit_pos_q, bit_pos_d;
	logic [7:0]    shift_q, shift_d;
	logic [CW-1:0] byte_cnt_q, byte_cnt_d;
	logic          end_seen_q, end_seen_d;
	logic          ack_seen_q, ack_seen_d;
	event_t        ev;
	logic [7:0]    data;
	logic [CW-1:0] idx;
	logic          data_slot;

	assign data_slot = (bit_pos_q < BIT_EOM);

	// next state and event for one edge
	always_comb begin
		start_seen_d = start_seen_q;
		bit_pos_d    = bit_pos_q;
		shift_d      = shift_q;
		byte_cnt_d   = byte_cnt_q;
		end_seen_d   = end_seen_q;
		ack_seen_d   = ack_seen_q;
		ev           = EV_IDLE;
		data         = 8'd0;
		idx          = '0;
		if (!edge_level) begin
			// falling edge: report ack at bit 9
			if (bit_pos_q == BIT_ACK) begin
				ack_seen_d = 1'b1;
				bit_pos_d  = 4'd0;
				ev         = EV_ACK;
			end
		end else if (cls.start_hit) begin
			start_seen_d = 1'b1;
			end_seen_d   = 1'b0;
			ack_seen_d   = 1'b0;
			byte_cnt_d   = '0;
			bit_pos_d    = 4'd0;
			shift_d      = 8'd0;
			ev           = EV_START;
		end else if (cls.one_hit || cls.zero_hit) begin
			ev = EV_BIT;
			if (cls.one_hit) begin
				if (start_seen_q) begin
					if (data_slot) begin
						shift_d = {shift_q[6:0], 1'b1};
					end else begin
						end_seen_d = 1'b1;
						ev         = EV_EOM;
					end
				end
			end else begin
				if (start_seen_q && data_slot) begin
					shift_d = {shift_q[6:0], 1'b0};
				end else begin
					ack_seen_d = 1'b1;
					ev         = EV_STRAY;
				end
			end
			// last data bit closes the byte (including that bit); count saturates
			if (bit_pos_q == BIT_LAST_DATA) begin
				if (byte_cnt_q < CNT_MAX) begin
					idx        = byte_cnt_q;
					byte_cnt_d = byte_cnt_q + 1'b1;
				end else begin
					idx = CNT_LAST;
				end
				data = shift_d;
				ev   = EV_BYTE;
			end
			bit_pos_d = bit_pos_q + 4'd1;
		end else begin
			// framing error
			start_seen_d = 1'b0;
			ev           = EV_ERROR;
		end
	end

	// result word
	always_comb begin
		result.event_code   = ev;
		result.data_byte    = data;
		result.byte_index   = 4'(idx);
		result.message_done = end_seen_d;
		result.ack_flag     = ack_seen_d;
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_seen_q <= 1'b0;
			bit_pos_q    <= 4'd0;
			shift_q      <= 8'd0;
			byte_cnt_q   <= '0;
			end_seen_q   <= 1'b0;
			ack_seen_q   <= 1'b0;
		end else if (advance) begin
			start_seen_q <= start_seen_d;
			bit_pos_q    <= bit_pos_d;
			shift_q      <= shift_d;
			byte_cnt_q   <= byte_cnt_d;
			end_seen_q   <= end_seen_d;
			ack_seen_q   <= ack_seen_d;
		end
	end

endmodule

### src/cec_pulse_width_receiver.sv
// ----------------------------------------------------------------------------
// CEC pulse width receiver
// Decodes CEC bus edges into start, data bit, byte, end-of-message, ack, stray,
// idle and framing error events.
// ----------------------------------------------------------------------------
// Each input word is one bus edge (tuser = level after the edge, tdata = low
// time in ticks). Every edge yields exactly one result word. One edge is taken
// per clock cycle while the output is not stalled by m_axis_tready; a word passes
// an input register and then a result register before its result is offered.
// The window compares, bit shifter and byte counter all sit between those two
// registers, which sets the one-word-per-cycle figure. The nominal low times
// and tolerance are APB registers at byte addresses 0, 4, 8 and 12; write them
// only while no edge is in flight.
module cec_pulse_width_receiver import cecpwr_pkg::*; #(
	parameter int unsigned MAX_MESSAGE_BYTES = 16,
	parameter int unsigned TICK_WIDTH        = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// stream in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] low_duration
	input  logic [0:0]  s_axis_tuser,   // [0] edge_level
	// stream out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [11:8] byte_index,
	                                    // [12] message_done, [13] ack_flag, [15:14] zero
	output logic [2:0]  m_axis_tuser,   // [2:0] event_code
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// only the low TICK_WIDTH bits of the low time count
	localparam logic [TICKW-1:0] TICK_MASK = (TICK_WIDTH >= TICKW) ? {TICKW{1'b1}} :
		TICKW'((64'd1 << TICK_WIDTH) - 64'd1);

	cfg_t             cfg;
	class_t           cls;
	result_t          result;
	logic             valid_s1;
	logic             edge_level_s1;
	logic [TICKW-1:0] low_time_s1;
	logic             valid_s2;
	result_t          result_s2;
	logic             advance;

	// handshake: stage 1 moves on when the result register is free or drains
	assign advance       = valid_s1 & (~valid_s2 | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;

	cecpwr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			edge_level_s1 <= s_axis_tuser[0];
			low_time_s1   <= s_axis_tdata & TICK_MASK;
		end
	end

	cecpwr_classify u_classify (
		.low_time (low_time_s1),
		.cfg      (cfg),
		.cls      (cls)
	);

	cecpwr_decode #(
		.MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
	) u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.edge_level (edge_level_s1),
		.cls        (cls),
		.result     (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (~valid_s2 | m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = result_s2.event_code;
	assign m_axis_tdata  = {2'b00, result_s2.ack_flag, result_s2.message_done,
		result_s2.byte_index, result_s2.data_byte};

endmodule
